// ===== sv/septr_pkg.sv =====
// ----------------------------------------------------------------------------
// septr_pkg: shared types and constants
// Event codes, ring geometry, queued command word and back-end state encoding
// for the pulse timeline ring.
// ----------------------------------------------------------------------------
package septr_pkg;

   localparam int VT_WIDTH      = 56;
   localparam int DUE_WIDTH     = 40;
   localparam int PRELOAD_WIDTH = 17;
   localparam logic [PRELOAD_WIDTH-1:0] PRELOAD_RESET = 17'd5632;

   // ring geometry; the depth is a power of two so the slot is the low index bits
   localparam int RING_DEPTH     = 131072;
   localparam int RING_AW        = 17;
   localparam int INDEX_WIDTH    = 40;
   localparam int TICKS_PER_SLOT = 1000;
   localparam int SLOT_REM_WIDTH = 10;

   // p / 1000 == (p * TICK_RECIP) >> TICK_SHIFT for every 32-bit p
   localparam logic [31:0] TICK_RECIP = 32'd274877907;
   localparam int          TICK_SHIFT = 38;

   localparam logic [2:0] KIND_PULSE  = 3'd0;
   localparam logic [2:0] KIND_TICK   = 3'd1;
   localparam logic [2:0] KIND_WAKE   = 3'd2;
   localparam logic [2:0] KIND_IDLE   = 3'd3;
   localparam logic [2:0] KIND_SHIP   = 3'd4;
   localparam logic [2:0] KIND_RESET  = 3'd5;

   localparam logic [7:0] BIT_XSTEP = 8'h01;
   localparam logic [7:0] BIT_XDIR  = 8'h02;
   localparam logic [7:0] BIT_YSTEP = 8'h04;
   localparam logic [7:0] BIT_YDIR  = 8'h08;
   localparam logic [7:0] BIT_ZSTEP = 8'h20;
   localparam logic [7:0] BIT_ZDIR  = 8'h40;

   typedef struct packed {
      logic [2:0]           kind;
      logic [7:0]           pulse_byte;
      logic [31:0]          period;
      logic [DUE_WIDTH-1:0] due_index;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_status_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_TICK_SPLIT,
      BK_TICK_ADD,
      BK_SUM,
      BK_CLAMP,
      BK_PLACE,
      BK_SHIP_RD,
      BK_SHIP
   } bk_state_type;

   function automatic logic [7:0] encode_pulse(input logic [2:0] st, input logic [2:0] dr);
      logic [7:0] b;
      b = '0;
      if (st[0]) b = b | BIT_XSTEP | (dr[0] ? BIT_XDIR : 8'h00);
      if (st[1]) b = b | BIT_YSTEP | (dr[1] ? 8'h00 : BIT_YDIR);
      if (st[2]) b = b | BIT_ZSTEP | (dr[2] ? 8'h00 : BIT_ZDIR);
      return b;
   endfunction

endpackage

// ===== sv/septr_front.sv =====
// ----------------------------------------------------------------------------
// septr_front: event intake
// Accepts event words, encodes pulses into motion bytes and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module septr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_kind,
   input  logic [2:0]               req_step_bits,
   input  logic [2:0]               req_dir_bits,
   input  logic [31:0]              req_period,
   input  logic [39:0]              req_due_index,
   input  septr_pkg::bk_status_type bk_status,
   output logic                     cmd_valid,
   output septr_pkg::cmd_type       cmd
);
   import septr_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    word;

   assign req_stall = (count_ff == 2'd2) || bk_status.clearing;
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      word.kind       = req_kind;
      word.pulse_byte = encode_pulse(req_step_bits, req_dir_bits);
      word.period     = req_period;
      word.due_index  = req_due_index;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = bk_status.pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, bk_status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== sv/septr_back.sv =====
// ----------------------------------------------------------------------------
// septr_back: timeline engine
// Owns the slot ring and stream indexes, keeps slot time as a running
// quotient and remainder of the virtual clock, and holds the result register.
// ----------------------------------------------------------------------------
module septr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  septr_pkg::cmd_type        cmd,
   output septr_pkg::bk_status_type  bk_status,
   input  logic [16:0]               preload_depth,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_pulse_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_run_started,
   output logic                      rsp_stream_finished,
   output logic                      rsp_stop_requested,
   output logic                      rsp_fault,
   output logic                      rsp_late_clamped
);
   import septr_pkg::*;

   localparam int IW  = INDEX_WIDTH;
   localparam int AW  = RING_AW;
   localparam int RMW = SLOT_REM_WIDTH;
   localparam logic [VT_WIDTH-1:0] VT_MAX = '1;
   localparam logic [VT_WIDTH-1:0] SAT_Q  = VT_MAX / VT_WIDTH'(TICKS_PER_SLOT);
   localparam logic [RMW-1:0]      SAT_R  = RMW'(VT_MAX % VT_WIDTH'(TICKS_PER_SLOT));

   logic [7:0] ring [RING_DEPTH];

   bk_state_type state_ff, state_in;
   logic [IW-1:0] produced_ff, produced_in;
   logic [IW-1:0] shipped_ff, shipped_in;
   logic [IW-1:0] epoch_ff, epoch_in;
   logic [VT_WIDTH-1:0] vt_ff, vt_in;
   logic streaming_ff, streaming_in;
   logic running_ff, running_in;
   logic failed_ff, failed_in;
   logic [AW-1:0] clr_ff, clr_in;

   // slot time = vt / TICKS_PER_SLOT kept as quotient and remainder
   logic [VT_WIDTH-1:0] slot_q_ff, slot_q_in;
   logic [RMW-1:0]      slot_r_ff, slot_r_in;
   logic [31:0]         period_ff, period_in;
   logic [31:0]         tq_ff, tq_in;
   logic [RMW-1:0]      tr_ff, tr_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [7:0]          byte_ff, byte_in;
   logic                late_ff, late_in;

   logic       mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0] mem_wd;
   logic       mem_re;
   logic [AW-1:0] mem_ra;
   logic [7:0] rd_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_out_ff, byte_out_in;
   logic [5:0] flags_ff, flags_in;
   logic       out_free;

   logic [31:0]   period_eff;
   logic [VT_WIDTH:0] vt_sum;
   logic [63:0]   tick_prod;
   logic [RMW:0]  rem_sum;
   logic [IW-1:0] backlog;
   logic [IW-1:0] preload_ext;
   logic [IW-1:0] due_ext;
   logic [IW-1:0] diff;
   logic          need_ok;

   assign out_free            = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pulse_byte      = byte_out_ff;
   assign rsp_byte_valid      = flags_ff[0];
   assign rsp_run_started     = flags_ff[1];
   assign rsp_stream_finished = flags_ff[2];
   assign rsp_stop_requested  = flags_ff[3];
   assign rsp_fault           = flags_ff[4];
   assign rsp_late_clamped    = flags_ff[5];

   always_comb begin
      period_eff  = (cmd.period == 32'd0) ? 32'd1 : cmd.period;
      vt_sum      = {1'b0, vt_ff} + (VT_WIDTH + 1)'(period_eff);
      tick_prod   = 64'(period_eff) * 64'(TICK_RECIP);
      rem_sum     = {1'b0, slot_r_ff} + {1'b0, tr_ff};
      backlog     = (produced_ff > shipped_ff) ? (produced_ff - shipped_ff) : '0;
      preload_ext = IW'(preload_depth);
      due_ext     = IW'(cmd.due_index);
      diff        = idx_ff - shipped_ff;
      need_ok     = (backlog >= (streaming_ff ? preload_ext : IW'(1)));

      state_in     = state_ff;
      produced_in  = produced_ff;
      shipped_in   = shipped_ff;
      epoch_in     = epoch_ff;
      vt_in        = vt_ff;
      streaming_in = streaming_ff;
      running_in   = running_ff;
      failed_in    = failed_ff;
      clr_in       = clr_ff;
      slot_q_in    = slot_q_ff;
      slot_r_in    = slot_r_ff;
      period_in    = period_ff;
      tq_in        = tq_ff;
      tr_in        = tr_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      late_in      = late_ff;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = '0;
      bk_status.pop      = 1'b0;
      bk_status.clearing = (state_ff == BK_CLEAR);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_out_in  = byte_out_ff;
      flags_in     = flags_ff;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(RING_DEPTH - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               bk_status.pop = 1'b1;
               rsp_valid_in  = 1'b1;
               byte_out_in   = 8'h00;
               flags_in      = '0;
               unique case (cmd.kind)
                  KIND_PULSE: begin
                     if (!failed_ff && cmd.pulse_byte != 8'h00 && streaming_ff) begin
                        rsp_valid_in = 1'b0;
                        byte_in      = cmd.pulse_byte;
                        state_in     = BK_SUM;
                     end
                  end
                  KIND_TICK: begin
                     if (vt_sum[VT_WIDTH]) begin
                        vt_in     = '1;
                        slot_q_in = SAT_Q;
                        slot_r_in = SAT_R;
                     end else begin
                        vt_in     = vt_sum[VT_WIDTH-1:0];
                        period_in = period_eff;
                        tq_in     = 32'(tick_prod[63:TICK_SHIFT]);
                        state_in  = BK_TICK_SPLIT;
                     end
                  end
                  KIND_WAKE: begin
                     if (!failed_ff && !streaming_ff) begin
                        streaming_in = 1'b1;
                        vt_in        = '0;
                        slot_q_in    = '0;
                        slot_r_in    = '0;
                        if (!running_ff) begin
                           shipped_in  = '0;
                           produced_in = preload_ext;
                           epoch_in    = preload_ext;
                        end else begin
                           produced_in = (due_ext > produced_ff) ? due_ext : produced_ff;
                           epoch_in    = (due_ext > produced_ff) ? due_ext : produced_ff;
                        end
                     end
                  end
                  KIND_IDLE: begin
                     streaming_in = 1'b0;
                  end
                  KIND_SHIP: begin
                     if (!failed_ff) begin
                        if (!streaming_ff && backlog == '0) begin
                           running_in  = 1'b0;
                           flags_in[2] = running_ff;
                        end else if ((shipped_ff != '0 && running_ff) || need_ok) begin
                           rsp_valid_in = 1'b0;
                           state_in     = BK_SHIP_RD;
                        end
                     end
                  end
                  KIND_RESET: begin
                     produced_in  = shipped_ff;
                     streaming_in = 1'b0;
                     running_in   = 1'b0;
                     flags_in[3]  = running_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_TICK_SPLIT: begin
            // remainder of this period's ticks
            tr_in    = RMW'(period_ff - (tq_ff * 32'(TICKS_PER_SLOT)));
            state_in = BK_TICK_ADD;
         end
         BK_TICK_ADD: begin
            if (rem_sum >= (RMW + 1)'(TICKS_PER_SLOT)) begin
               slot_r_in = RMW'(rem_sum - (RMW + 1)'(TICKS_PER_SLOT));
               slot_q_in = slot_q_ff + VT_WIDTH'(tq_ff) + VT_WIDTH'(1);
            end else begin
               slot_r_in = rem_sum[RMW-1:0];
               slot_q_in = slot_q_ff + VT_WIDTH'(tq_ff);
            end
            state_in = BK_IDLE;
         end
         BK_SUM: begin
            idx_in   = epoch_ff + IW'(slot_q_ff);
            state_in = BK_CLAMP;
         end
         BK_CLAMP: begin
            late_in = (idx_ff < shipped_ff);
            if (idx_ff < shipped_ff) begin
               idx_in = (shipped_ff < produced_ff) ? produced_ff : shipped_ff;
            end else begin
               idx_in = (idx_ff < produced_ff) ? produced_ff : idx_ff;
            end
            state_in = BK_PLACE;
         end
         BK_PLACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_out_in  = 8'h00;
               flags_in     = '0;
               flags_in[5]  = late_ff;
               if (diff >= IW'(RING_DEPTH - 1)) begin
                  failed_in   = 1'b1;
                  flags_in[4] = 1'b1;
               end else begin
                  mem_we      = 1'b1;
                  mem_wa      = idx_ff[AW-1:0];
                  mem_wd      = byte_ff;
                  produced_in = idx_ff + IW'(1);
               end
               state_in = BK_IDLE;
            end
         end
         BK_SHIP_RD: begin
            mem_re   = 1'b1;
            mem_ra   = shipped_ff[AW-1:0];
            state_in = BK_SHIP;
         end
         BK_SHIP: begin
            if (out_free) begin
               mem_we       = 1'b1;
               mem_wa       = shipped_ff[AW-1:0];
               mem_wd       = 8'h00;
               shipped_in   = shipped_ff + IW'(1);
               running_in   = 1'b1;
               rsp_valid_in = 1'b1;
               byte_out_in  = rd_ff;
               flags_in     = '0;
               flags_in[0]  = 1'b1;
               flags_in[1]  = !running_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         produced_ff  <= '0;
         shipped_ff   <= '0;
         epoch_ff     <= '0;
         vt_ff        <= '0;
         streaming_ff <= 1'b0;
         running_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         clr_ff       <= '0;
         slot_q_ff    <= '0;
         slot_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         produced_ff  <= produced_in;
         shipped_ff   <= shipped_in;
         epoch_ff     <= epoch_in;
         vt_ff        <= vt_in;
         streaming_ff <= streaming_in;
         running_ff   <= running_in;
         failed_ff    <= failed_in;
         clr_ff       <= clr_in;
         slot_q_ff    <= slot_q_in;
         slot_r_ff    <= slot_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff   <= period_in;
      tq_ff       <= tq_in;
      tr_ff       <= tr_in;
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      late_ff     <= late_in;
      byte_out_ff <= byte_out_in;
      flags_ff    <= flags_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= ring[mem_ra];
      end
   end

endmodule

// ===== sv/step_event_pulse_timeline_ring_top.sv =====
// ----------------------------------------------------------------------------
// step_event_pulse_timeline_ring_top: stepper pulse timeline ring
// Event words in on req_*, one result word out on rsp_* per event word.
//   Every event word yields exactly one result word, in order. An event word
//   is taken when req_valid is high and req_stall low; a result word is taken
//   when rsp_valid is high and rsp_stall low.
//   An accepted word is registered into a two-word queue feeding the engine.
//   From there, tick, wakeup, go-idle, reset, ignored and waiting words go
//   straight from idle to the result register, a shipped byte through the
//   ring-read and ship states (ring read, then write-back of zero) and a
//   placed pulse through the slot sum, clamp and place states. A tick that
//   does not saturate keeps the engine busy through the split and add states
//   to fold the period into the slot quotient and remainder. One word is in
//   the engine at a time. After reset the ring is zeroed by a pass over all
//   RING_DEPTH (131072) slots, req_stall high; the csr port works throughout.
//   While rsp_stall holds, the finished result waits in the result register
//   and the engine holds its next finished word; the queue keeps taking words
//   until full.
//   csr: preload_depth at byte address 0, 17 bits, reset 5632.
// ----------------------------------------------------------------------------
module step_event_pulse_timeline_ring_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_step_bits,
   input  logic [2:0]  req_dir_bits,
   input  logic [31:0] req_period,
   input  logic [39:0] req_due_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pulse_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_run_started,
   output logic        rsp_stream_finished,
   output logic        rsp_stop_requested,
   output logic        rsp_fault,
   output logic        rsp_late_clamped,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import septr_pkg::*;

   logic [PRELOAD_WIDTH-1:0] preload_ff, preload_in;
   logic          cmd_valid;
   cmd_type       cmd;
   bk_status_type bk_status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(preload_ff) : 32'd0;

   always_comb begin
      preload_in = preload_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         preload_in = csr_pwdata[PRELOAD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preload_ff <= PRELOAD_RESET;
      end else begin
         preload_ff <= preload_in;
      end
   end

   septr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_step_bits (req_step_bits),
      .req_dir_bits  (req_dir_bits),
      .req_period    (req_period),
      .req_due_index (req_due_index),
      .bk_status     (bk_status),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   septr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .bk_status           (bk_status),
      .preload_depth       (preload_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pulse_byte      (rsp_pulse_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_run_started     (rsp_run_started),
      .rsp_stream_finished (rsp_stream_finished),
      .rsp_stop_requested  (rsp_stop_requested),
      .rsp_fault           (rsp_fault),
      .rsp_late_clamped    (rsp_late_clamped)
   );

endmodule
